// ===== src/energy_voice_activity_detector_assert.svh =====
// assertion macros for the energy voice activity detector
`ifndef ENERGY_VOICE_ACTIVITY_DETECTOR_ASSERT_SVH
`define ENERGY_VOICE_ACTIVITY_DETECTOR_ASSERT_SVH

// same-cycle implication, disabled during reset
`define EVAD_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("evad assertion failed");

// next-cycle implication, disabled during reset
`define EVAD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("evad assertion failed");

`endif

// ===== src/evad_pkg.sv =====
// shared types, constants and the reciprocal table of the voice activity detector
`timescale 1ns / 1ps

package evad_pkg;

   localparam int CSR_ADDR_WIDTH = 4;
   localparam int CSR_DATA_WIDTH = 32;
   localparam int MUL_A_WIDTH    = 24;
   localparam int MUL_B_WIDTH    = 16;

   // register indexes, taken from paddr[3:2]
   localparam logic [1:0] REG_LEVEL_SHIFT       = 2'd0;
   localparam logic [1:0] REG_CONFIDENCE_FRAMES = 2'd1;
   localparam logic [1:0] REG_THRESHOLD_FLOOR   = 2'd2;

   localparam logic [4:0]  LEVEL_SHIFT_RESET       = 5'd12;
   localparam logic [7:0]  CONFIDENCE_FRAMES_RESET = 8'd5;
   localparam logic [7:0]  THRESHOLD_FLOOR_RESET   = 8'd20;
   localparam logic [23:0] GROWTH_RESET            = 24'h010000;
   localparam logic [7:0]  SEED_MAX                = 8'd200;
   localparam logic [7:0]  SEED_MIN                = 8'd3;
   localparam logic [7:0]  LEVEL_MAX               = 8'd255;

   typedef struct packed {
      logic signed [15:0] sample;
      logic               frame_end;
   } req_type;

   typedef struct packed {
      logic [7:0] frame_level;
      logic [7:0] frame_threshold;
      logic       voice_active;
   } rsp_type;

   typedef struct packed {
      logic                   load;
      logic [MUL_A_WIDTH-1:0] a;
      logic [MUL_B_WIDTH-1:0] b;
   } mul_op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LEVEL,
      ST_LAMBDA,
      ST_BLEND,
      ST_THR,
      ST_GROW,
      ST_DONE
   } evad_state_type;

   // min(255, 256/(idx+1))
   function automatic logic [7:0] recip_rom(input logic [7:0] idx);
      logic [7:0] q;
      case (idx) inside
         8'd0:            q = 8'd255;
         8'd1:            q = 8'd128;
         8'd2:            q = 8'd85;
         8'd3:            q = 8'd64;
         8'd4:            q = 8'd51;
         8'd5:            q = 8'd42;
         8'd6:            q = 8'd36;
         8'd7:            q = 8'd32;
         8'd8:            q = 8'd28;
         8'd9:            q = 8'd25;
         8'd10:           q = 8'd23;
         8'd11:           q = 8'd21;
         8'd12:           q = 8'd19;
         8'd13:           q = 8'd18;
         8'd14:           q = 8'd17;
         8'd15:           q = 8'd16;
         8'd16:           q = 8'd15;
         8'd17:           q = 8'd14;
         8'd18:           q = 8'd13;
         [8'd19:8'd20]:   q = 8'd12;
         [8'd21:8'd22]:   q = 8'd11;
         [8'd23:8'd24]:   q = 8'd10;
         [8'd25:8'd27]:   q = 8'd9;
         [8'd28:8'd31]:   q = 8'd8;
         [8'd32:8'd35]:   q = 8'd7;
         [8'd36:8'd41]:   q = 8'd6;
         [8'd42:8'd50]:   q = 8'd5;
         [8'd51:8'd63]:   q = 8'd4;
         [8'd64:8'd84]:   q = 8'd3;
         [8'd85:8'd127]:  q = 8'd2;
         default:         q = 8'd1;
      endcase
      return q;
   endfunction

endpackage

// ===== src/evad_mul_unit.sv =====
// shared multiplier with registered low product bits
`timescale 1ns / 1ps

module evad_mul_unit (
   input  logic                                           clock,
   input  evad_pkg::mul_op_type                           mul_op,
   output logic [evad_pkg::MUL_A_WIDTH-1:0]               product_ff
);

   logic [evad_pkg::MUL_A_WIDTH+evad_pkg::MUL_B_WIDTH-1:0] full_product;
   logic [evad_pkg::MUL_A_WIDTH-1:0]                       product_in;

   assign full_product = mul_op.a * mul_op.b;

   // product holds while the sequencer is not using the unit
   assign product_in = mul_op.load ? full_product[evad_pkg::MUL_A_WIDTH-1:0] : product_ff;

   always_ff @(posedge clock) begin
      product_ff <= product_in;
   end

endmodule

// ===== src/energy_voice_activity_detector.sv =====
// energy voice activity detector: frame level, adaptive threshold and voice flag
`timescale 1ns / 1ps
`include "energy_voice_activity_detector_assert.svh"

// Accepts one signed 16-bit sample per beat and adds its magnitude into a 32-bit frame
// sum. A sample without frame_end gives no result. A sample with frame_end is followed
// by six sequencer steps (level and min/max tracking, lambda, blend, threshold and
// hysteresis, growth scaling, result load), where three multiplications share one 24x16
// multiplier with a registered product. The last step waits while a previous result is
// still stalled in the output register. req_stall is high during those steps. Registers:
// level_shift at 0x0, confidence_frames at 0x4, threshold_floor at 0x8; write them only
// while idle.
module energy_voice_activity_detector (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  evad_pkg::req_type                     req_data,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output evad_pkg::rsp_type                     rsp_data,
   input  logic                                  csr_psel,
   input  logic                                  csr_penable,
   input  logic                                  csr_pwrite,
   input  logic [evad_pkg::CSR_ADDR_WIDTH-1:0]   csr_paddr,
   input  logic [evad_pkg::CSR_DATA_WIDTH-1:0]   csr_pwdata,
   output logic [evad_pkg::CSR_DATA_WIDTH-1:0]   csr_prdata,
   output logic                                  csr_pready
);

   evad_pkg::evad_state_type state_ff, state_in;

   logic [4:0]  shift_ff, shift_in;
   logic [7:0]  conf_ff, conf_in;
   logic [7:0]  floor_ff, floor_in;

   logic [31:0] abs_sum_ff, abs_sum_in;
   logic        first_ff, first_in;
   logic [7:0]  max_ff, max_in;
   logic [7:0]  min_ff, min_in;
   logic [23:0] gf_ff, gf_in;
   logic        prev_ff, prev_in;
   logic        cur_ff, cur_in;
   logic [7:0]  act_ff, act_in;
   logic [7:0]  inact_ff, inact_in;
   logic        rsp_valid_ff, rsp_valid_in;

   logic [7:0]        level_ff, level_in;
   logic [7:0]        thr_ff, thr_in;
   evad_pkg::rsp_type rsp_data_ff, rsp_data_in;

   evad_pkg::mul_op_type mul_op;
   logic [evad_pkg::MUL_A_WIDTH-1:0] product;

   logic        req_accept;
   logic        csr_write;
   logic [16:0] mag;
   logic [31:0] shifted;
   logic [7:0]  level_w;
   logic [7:0]  seed_max, grown_max, track_max, seed_min, track_min;
   logic [8:0]  diff_w, ndiff_w;
   logic [15:0] blend_w;
   logic [7:0]  thr_w;
   logic        out_free;

   evad_mul_unit mul_unit (
      .clock      (clock),
      .mul_op     (mul_op),
      .product_ff (product)
   );

   assign req_accept = req_valid && !req_stall;
   assign req_stall  = (state_ff != evad_pkg::ST_IDLE);
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   // magnitude of the sample; -32768 gives 32768
   assign mag = req_data.sample[15] ? (17'd0 - {req_data.sample[15], req_data.sample})
                                    : {1'b0, req_data.sample};

   // level and min/max tracking
   assign shifted   = abs_sum_ff >> shift_ff;
   assign level_w   = (|shifted[31:8]) ? evad_pkg::LEVEL_MAX : shifted[7:0];
   assign seed_max  = first_ff ? ((level_w != 8'd0) ? level_w : evad_pkg::SEED_MAX) : max_ff;
   assign seed_min  = first_ff ? ((level_w != 8'd0) ? level_w : evad_pkg::SEED_MIN) : min_ff;
   assign grown_max = (level_w > seed_max) ? level_w : seed_max;
   assign track_max = (level_w < {3'd0, grown_max[7:3]}) ? (grown_max - 8'd1) : grown_max;
   assign track_min = (level_w < seed_min)
                      ? ((level_w == 8'd0) ? evad_pkg::SEED_MIN : level_w) : seed_min;

   assign diff_w  = {1'b0, max_ff} - {1'b0, min_ff};
   assign ndiff_w = {1'b0, min_ff} - {1'b0, max_ff};

   // (256-lambda)*max + lambda*min == 256*max + lambda*(min-max), low 16 bits
   assign blend_w = {max_ff, 8'h00} + product[15:0];
   assign thr_w   = (blend_w[15:8] < floor_ff) ? floor_ff : blend_w[15:8];

   always_comb begin
      state_in     = state_ff;
      shift_in     = shift_ff;
      conf_in      = conf_ff;
      floor_in     = floor_ff;
      abs_sum_in   = abs_sum_ff;
      first_in     = first_ff;
      max_in       = max_ff;
      min_in       = min_ff;
      gf_in        = gf_ff;
      prev_in      = prev_ff;
      cur_in       = cur_ff;
      act_in       = act_ff;
      inact_in     = inact_ff;
      level_in     = level_ff;
      thr_in       = thr_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      mul_op       = '0;

      if (csr_write) begin
         unique case (csr_paddr[3:2])
            evad_pkg::REG_LEVEL_SHIFT:       shift_in = csr_pwdata[4:0];
            evad_pkg::REG_CONFIDENCE_FRAMES: conf_in  = csr_pwdata[7:0];
            evad_pkg::REG_THRESHOLD_FLOOR:   floor_in = csr_pwdata[7:0];
            default: ;
         endcase
      end

      unique case (state_ff)
         evad_pkg::ST_IDLE: begin
            if (req_accept) begin
               abs_sum_in = abs_sum_ff + {15'd0, mag};
               if (req_data.frame_end) begin
                  state_in = evad_pkg::ST_LEVEL;
               end
            end
         end
         evad_pkg::ST_LEVEL: begin
            level_in   = level_w;
            max_in     = track_max;
            min_in     = track_min;
            first_in   = 1'b0;
            gf_in      = gf_ff + 24'd1;
            abs_sum_in = '0;
            state_in   = evad_pkg::ST_LAMBDA;
         end
         evad_pkg::ST_LAMBDA: begin
            mul_op.load = 1'b1;
            mul_op.a    = {{15{diff_w[8]}}, diff_w};
            mul_op.b    = {8'd0, evad_pkg::recip_rom(max_ff)};
            state_in    = evad_pkg::ST_BLEND;
         end
         evad_pkg::ST_BLEND: begin
            // lambda straight from the product register
            mul_op.load = 1'b1;
            mul_op.a    = {{15{ndiff_w[8]}}, ndiff_w};
            mul_op.b    = product[15:0];
            state_in    = evad_pkg::ST_THR;
         end
         evad_pkg::ST_THR: begin
            thr_in = thr_w;
            if ({2'd0, level_ff[7:2]} >= thr_w) begin
               min_in = {min_ff[6:0], 1'b0};
            end
            if (level_ff > thr_w) begin
               if (act_ff == conf_ff) begin
                  prev_in  = cur_ff;
                  cur_in   = 1'b1;
                  inact_in = 8'd0;
               end else begin
                  cur_in = prev_ff;
                  act_in = act_ff + 8'd1;
               end
            end else begin
               if (inact_ff == conf_ff) begin
                  prev_in = cur_ff;
                  cur_in  = 1'b0;
                  act_in  = 8'd0;
               end else begin
                  cur_in   = prev_ff;
                  inact_in = inact_ff + 8'd1;
               end
            end
            state_in = evad_pkg::ST_GROW;
         end
         evad_pkg::ST_GROW: begin
            mul_op.load = 1'b1;
            mul_op.a    = gf_ff;
            mul_op.b    = {8'd0, min_ff};
            state_in    = evad_pkg::ST_DONE;
         end
         evad_pkg::ST_DONE: begin
            // product holds, so repeating this while stalled is harmless
            min_in = product[23:16];
            if (out_free) begin
               rsp_data_in.frame_level     = level_ff;
               rsp_data_in.frame_threshold = thr_ff;
               rsp_data_in.voice_active    = cur_ff;
               rsp_valid_in                = 1'b1;
               state_in                    = evad_pkg::ST_IDLE;
            end
         end
         default: state_in = evad_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      unique case (csr_paddr[3:2])
         evad_pkg::REG_LEVEL_SHIFT:       csr_prdata = {27'd0, shift_ff};
         evad_pkg::REG_CONFIDENCE_FRAMES: csr_prdata = {24'd0, conf_ff};
         evad_pkg::REG_THRESHOLD_FLOOR:   csr_prdata = {24'd0, floor_ff};
         default:                         csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= evad_pkg::ST_IDLE;
         shift_ff     <= evad_pkg::LEVEL_SHIFT_RESET;
         conf_ff      <= evad_pkg::CONFIDENCE_FRAMES_RESET;
         floor_ff     <= evad_pkg::THRESHOLD_FLOOR_RESET;
         abs_sum_ff   <= '0;
         first_ff     <= 1'b1;
         max_ff       <= '0;
         min_ff       <= '0;
         gf_ff        <= evad_pkg::GROWTH_RESET;
         prev_ff      <= 1'b0;
         cur_ff       <= 1'b0;
         act_ff       <= '0;
         inact_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         shift_ff     <= shift_in;
         conf_ff      <= conf_in;
         floor_ff     <= floor_in;
         abs_sum_ff   <= abs_sum_in;
         first_ff     <= first_in;
         max_ff       <= max_in;
         min_ff       <= min_in;
         gf_ff        <= gf_in;
         prev_ff      <= prev_in;
         cur_ff       <= cur_in;
         act_ff       <= act_in;
         inact_ff     <= inact_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      level_ff    <= level_in;
      thr_ff      <= thr_in;
      rsp_data_ff <= rsp_data_in;
   end

   `EVAD_ASSERT_NEXT(a_frame_end_starts_seq, clock, reset, req_accept && req_data.frame_end, state_ff == evad_pkg::ST_LEVEL)
   `EVAD_ASSERT_NEXT(a_done_waits_on_stall, clock, reset, (state_ff == evad_pkg::ST_DONE) && rsp_valid_ff && rsp_stall, (state_ff == evad_pkg::ST_DONE) && rsp_valid_ff)
   `EVAD_ASSERT_NEXT(a_first_frame_cleared, clock, reset, state_ff == evad_pkg::ST_LEVEL, !first_ff)
   `EVAD_ASSERT_NEXT(a_busy_no_new_result, clock, reset, (state_ff != evad_pkg::ST_DONE) && !rsp_valid_ff, !rsp_valid_ff)

endmodule
